// ===== src/amk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amk_pkg
// Shared types, constants and the Morse code table for the keying encoder.
// ----------------------------------------------------------------------------
package amk_pkg;

    localparam int CODE_MAX_LEN_DEFAULT = 6;
    localparam int PAT_W                = 8;
    localparam int LEN_W                = 4;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic [1:0] MARK_NONE = 2'd0;
    localparam logic [1:0] MARK_DOT  = 2'd1;
    localparam logic [1:0] MARK_DASH = 2'd3;
    localparam logic [2:0] GAP_ELEM  = 3'd1;
    localparam logic [2:0] GAP_CHAR  = 3'd3;
    localparam logic [2:0] GAP_WORD  = 3'd4;

    // pattern holds the first element at bit len-1, 1 = dash
    typedef struct packed {
        logic             found;
        logic             is_space;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
    } morse_code_t;

    // datapath controls from the sequencer
    typedef struct packed {
        logic load;
        logic decode;
        logic emit;
    } amk_ctl_t;

    // datapath status back to the sequencer
    typedef struct packed {
        logic found;
        logic out_free;
        logic more;
    } amk_stat_t;

    function automatic morse_code_t mk(input logic [LEN_W-1:0] len,
                                       input logic [PAT_W-1:0] pat);
        morse_code_t r;
        r.found    = 1'b1;
        r.is_space = 1'b0;
        r.len      = len;
        r.pat      = pat;
        return r;
    endfunction

    function automatic morse_code_t morse_lookup(input logic [7:0] code_in);
        logic [7:0]  c;
        morse_code_t r;
        c = code_in;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            c = c + CASE_OFFSET;
        end
        r = '0;
        case (c)
            CHAR_SPACE: begin
                r.found    = 1'b1;
                r.is_space = 1'b1;
                r.len      = LEN_W'(1);
            end
            8'h61: r = mk(4'd2, 8'b01);
            8'h62: r = mk(4'd4, 8'b1000);
            8'h63: r = mk(4'd4, 8'b1010);
            8'h64: r = mk(4'd3, 8'b100);
            8'h65: r = mk(4'd1, 8'b0);
            8'h66: r = mk(4'd4, 8'b0010);
            8'h67: r = mk(4'd3, 8'b110);
            8'h68: r = mk(4'd4, 8'b0000);
            8'h69: r = mk(4'd2, 8'b00);
            8'h6a: r = mk(4'd4, 8'b0111);
            8'h6b: r = mk(4'd3, 8'b101);
            8'h6c: r = mk(4'd4, 8'b0100);
            8'h6d: r = mk(4'd2, 8'b11);
            8'h6e: r = mk(4'd2, 8'b10);
            8'h6f: r = mk(4'd3, 8'b111);
            8'h70: r = mk(4'd4, 8'b0110);
            8'h71: r = mk(4'd4, 8'b1101);
            8'h72: r = mk(4'd3, 8'b010);
            8'h73: r = mk(4'd3, 8'b000);
            8'h74: r = mk(4'd1, 8'b1);
            8'h75: r = mk(4'd3, 8'b001);
            8'h76: r = mk(4'd4, 8'b0001);
            8'h77: r = mk(4'd3, 8'b011);
            8'h78: r = mk(4'd4, 8'b1001);
            8'h79: r = mk(4'd4, 8'b1011);
            8'h7a: r = mk(4'd4, 8'b1100);
            8'h30: r = mk(4'd5, 8'b11111);
            8'h31: r = mk(4'd5, 8'b01111);
            8'h32: r = mk(4'd5, 8'b00111);
            8'h33: r = mk(4'd5, 8'b00011);
            8'h34: r = mk(4'd5, 8'b00001);
            8'h35: r = mk(4'd5, 8'b00000);
            8'h36: r = mk(4'd5, 8'b10000);
            8'h37: r = mk(4'd5, 8'b11000);
            8'h38: r = mk(4'd5, 8'b11100);
            8'h39: r = mk(4'd5, 8'b11110);
            8'h2e: r = mk(4'd6, 8'b010101);  // full stop
            8'h2c: r = mk(4'd6, 8'b110011);  // comma
            8'h3f: r = mk(4'd6, 8'b001100);  // question mark
            8'h27: r = mk(4'd6, 8'b011110);  // apostrophe
            8'h21: r = mk(4'd6, 8'b101011);  // exclamation mark
            8'h2f: r = mk(4'd5, 8'b10010);   // slash
            8'h28: r = mk(4'd5, 8'b10110);   // open bracket
            8'h29: r = mk(4'd6, 8'b101101);  // close bracket
            8'h26: r = mk(4'd5, 8'b01000);   // ampersand
            8'h3a: r = mk(4'd6, 8'b111000);  // colon
            8'h3d: r = mk(4'd5, 8'b10001);   // equals
            8'h2b: r = mk(4'd5, 8'b01010);   // plus
            8'h2d: r = mk(4'd6, 8'b100001);  // hyphen
            8'h22: r = mk(4'd6, 8'b010010);  // double quote
            8'h40: r = mk(4'd6, 8'b011010);  // at sign
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/amk_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amk_sequencer
// Step counter and control store; each step's word drives the datapath and
// picks the next step from one condition, input valid or a datapath status.
// ----------------------------------------------------------------------------
module amk_sequencer
    import amk_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  amk_stat_t      stat,
    output amk_ctl_t       ctl
);

    typedef logic [1:0] step_t;

    typedef enum logic [1:0] {
        COND_ACCEPT   = 2'd0,
        COND_FOUND    = 2'd1,
        COND_OUT_FREE = 2'd2,
        COND_MORE     = 2'd3
    } cond_t;

    typedef struct packed {
        logic  ready;
        logic  decode;
        logic  emit;
        cond_t cond;
        step_t on_true;
        step_t on_false;
    } ucode_t;

    localparam step_t STEP_FETCH  = 2'd0;
    localparam step_t STEP_DECODE = 2'd1;
    localparam step_t STEP_SEND   = 2'd2;
    localparam step_t STEP_NEXT   = 2'd3;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '0;
        unique case (step)
            STEP_FETCH: begin
                w.ready    = 1'b1;
                w.cond     = COND_ACCEPT;
                w.on_true  = STEP_DECODE;
                w.on_false = STEP_FETCH;
            end
            STEP_DECODE: begin
                w.decode   = 1'b1;
                w.cond     = COND_FOUND;
                w.on_true  = STEP_SEND;
                w.on_false = STEP_FETCH;
            end
            STEP_SEND: begin
                w.emit     = 1'b1;
                w.cond     = COND_OUT_FREE;
                w.on_true  = STEP_NEXT;
                w.on_false = STEP_SEND;
            end
            STEP_NEXT: begin
                w.cond     = COND_MORE;
                w.on_true  = STEP_SEND;
                w.on_false = STEP_FETCH;
            end
            default: w = '0;
        endcase
        return w;
    endfunction

    step_t  step_reg;
    step_t  step_next;
    ucode_t uw;
    logic   cond_hit;

    assign uw       = ucode_rom(step_reg);
    assign in_ready = uw.ready;

    assign ctl.load   = uw.ready & in_valid;
    assign ctl.decode = uw.decode;
    assign ctl.emit   = uw.emit;

    always_comb begin
        unique case (uw.cond)
            COND_ACCEPT:   cond_hit = in_valid;
            COND_FOUND:    cond_hit = stat.found;
            COND_OUT_FREE: cond_hit = stat.out_free;
            COND_MORE:     cond_hit = stat.more;
            default:       cond_hit = 1'b0;
        endcase
        step_next = cond_hit ? uw.on_true : uw.on_false;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/amk_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amk_datapath
// Character register, table decode into pattern and element count, and the
// result output register.
// ----------------------------------------------------------------------------
module amk_datapath
    import amk_pkg::*;
#(
    parameter int CODE_MAX_LEN = CODE_MAX_LEN_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  amk_ctl_t        ctl,
    output amk_stat_t       stat,
    input  wire logic [7:0] char_code,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      mark_units,
    output logic [2:0]      gap_units,
    output logic            last_element
);

    localparam int CNT_W = $clog2(CODE_MAX_LEN + 1);
    localparam int IDX_W = $clog2(CODE_MAX_LEN);

    logic [7:0]              char_reg;
    logic [CODE_MAX_LEN-1:0] pat_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    space_reg;
    logic                    valid_reg;
    logic [1:0]              mark_reg;
    logic [2:0]              gap_reg;
    logic                    last_reg;

    morse_code_t             code;
    logic [CNT_W-1:0]        len_trunc;
    logic [PAT_W-1:0]        pat_full;
    logic [CNT_W-1:0]        cnt_m1;
    logic [IDX_W-1:0]        elem_idx;
    logic                    out_free;
    logic                    elem_last;
    logic                    elem_dash;

    assign code = morse_lookup(char_reg);

    // keep the first CODE_MAX_LEN elements of an over-long run
    always_comb begin
        if (int'(code.len) > CODE_MAX_LEN) begin
            len_trunc = CNT_W'(CODE_MAX_LEN);
        end else begin
            len_trunc = CNT_W'(code.len);
        end
        pat_full = code.pat >> (code.len - LEN_W'(len_trunc));
    end

    assign cnt_m1    = count_reg - CNT_W'(1);
    assign elem_idx  = cnt_m1[IDX_W-1:0];
    assign elem_dash = pat_reg[elem_idx];
    assign elem_last = (count_reg == CNT_W'(1));
    assign out_free  = !valid_reg || out_ready;

    assign stat.found    = code.found;
    assign stat.out_free = out_free;
    assign stat.more     = (count_reg != '0);

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            char_reg <= char_code;
        end
        if (ctl.decode) begin
            pat_reg   <= pat_full[CODE_MAX_LEN-1:0];
            count_reg <= len_trunc;
            space_reg <= code.is_space;
        end else if (ctl.emit && out_free) begin
            count_reg <= cnt_m1;
        end
        if (ctl.emit && out_free) begin
            if (space_reg) begin
                mark_reg <= MARK_NONE;
                gap_reg  <= GAP_WORD;
            end else begin
                mark_reg <= elem_dash ? MARK_DASH : MARK_DOT;
                gap_reg  <= elem_last ? GAP_CHAR : GAP_ELEM;
            end
            last_reg <= elem_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.emit && out_free) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign out_valid    = valid_reg;
    assign mark_units   = mark_reg;
    assign gap_units    = gap_reg;
    assign last_element = last_reg;

endmodule
`default_nettype wire

// ===== src/ascii_to_morse_keying.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_to_morse_keying
// ASCII character in, Morse keying elements out, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Each input item is one ASCII character; each output item is one keying
// element (mark length, gap length, tlast on the final element of the
// character). Upper case is folded to lower case, a space gives a single
// element with no mark and a four-unit gap, and characters outside the table
// give no output at all. The four-step control program runs fetch, decode,
// then a send and a next-element step per element; a character outside the
// table returns to fetch after decode. No new character is taken before
// fetch, and output back-pressure holds the send step until the output is free.
module ascii_to_morse_keying
    import amk_pkg::*;
#(
    parameter int CODE_MAX_LEN = CODE_MAX_LEN_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_code
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [1:0] mark_units, [4:2] gap_units, [7:5] zero
    output logic            m_tlast    // last_element
);

    amk_ctl_t   ctl;
    amk_stat_t  stat;
    logic [1:0] mark_units;
    logic [2:0] gap_units;

    amk_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    amk_datapath #(
        .CODE_MAX_LEN (CODE_MAX_LEN)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .stat         (stat),
        .char_code    (s_tdata),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .mark_units   (mark_units),
        .gap_units    (gap_units),
        .last_element (m_tlast)
    );

    assign m_tdata = {3'b000, gap_units, mark_units};

endmodule
`default_nettype wire

// ===== src/amk_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amk_checker
// Port-level checks for the Morse keying encoder, bound to the top level.
// ----------------------------------------------------------------------------
module amk_checker
    import amk_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // one character at a time: no new item right after an accepted one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // word space is a lone element with no mark
    a_space_elem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4:2] == GAP_WORD) |-> (m_tdata[1:0] == MARK_NONE) && m_tlast)
        else $error("bad word space element");

    // element gap follows tlast
    a_gap_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != MARK_NONE) |->
            (m_tlast ? (m_tdata[4:2] == GAP_CHAR) : (m_tdata[4:2] == GAP_ELEM))
            && (m_tdata[7:5] == 3'b000))
        else $error("gap does not match element position");

endmodule

bind ascii_to_morse_keying amk_checker u_amk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ASCII to Morse keying encoder: a directed table
// of edge characters, then random text, run under several idle and stall
// patterns on both stream channels. Typed rows carry their own expected item;
// all other output is checked against a predictor on its own ITU code table.
// ----------------------------------------------------------------------------
module testbench
    import amk_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int ITEMS_PER_PHASE = 84;
    localparam int DRAIN_CYCLES   = 30;
    localparam int N_ROWS         = 25;

    typedef struct packed {
        logic [1:0] mark;
        logic [2:0] gap;
        logic       last;
    } keying_elem_t;

    // one directed row: character, typed expectation flag, element count, element
    typedef struct packed {
        logic [7:0]   code;
        logic         typed;
        logic [2:0]   n_elems;
        keying_elem_t elem;
    } char_row_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] char_code
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;   // [1:0] mark_units, [4:2] gap_units, [7:5] zero
    logic       m_tlast;   // last_element

    keying_elem_t pending_elems[$];
    keying_elem_t want;
    int           fail_count    = 0;
    int           elems_seen    = 0;
    int           quiet_cycles  = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_left     = 0;
    bit           hold_done     = 1'b0;
    string        itu_chars =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?'!/()&:=+-\"@";

    char_row_t char_rows [0:N_ROWS-1] = '{
        {8'h00, 1'b1, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},   // nul
        {8'h1f, 1'b1, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},   // control code
        {8'h20, 1'b1, 3'd1, MARK_NONE, GAP_WORD, 1'b1},   // word space
        {8'h65, 1'b1, 3'd1, MARK_DOT,  GAP_CHAR, 1'b1},   // e
        {8'h45, 1'b1, 3'd1, MARK_DOT,  GAP_CHAR, 1'b1},   // E folded
        {8'h74, 1'b1, 3'd1, MARK_DASH, GAP_CHAR, 1'b1},   // t
        {8'h54, 1'b1, 3'd1, MARK_DASH, GAP_CHAR, 1'b1},   // T folded
        {8'h5b, 1'b1, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},   // just above Z
        {8'h60, 1'b1, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},   // just below a
        {8'h7f, 1'b1, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},
        {8'h80, 1'b1, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},
        {8'hff, 1'b1, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},
        {8'h41, 1'b0, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},   // A
        {8'h5a, 1'b0, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},   // Z
        {8'h61, 1'b0, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},   // a
        {8'h7a, 1'b0, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},   // z
        {8'h30, 1'b0, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},   // 0, all dashes
        {8'h35, 1'b0, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},   // 5, all dots
        {8'h39, 1'b0, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},
        {8'h2e, 1'b0, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},   // six elements
        {8'h2c, 1'b0, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},
        {8'h2d, 1'b0, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},
        {8'h22, 1'b0, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},
        {8'h27, 1'b0, 3'd0, MARK_NONE, GAP_ELEM, 1'b0},
        {8'h40, 1'b0, 3'd0, MARK_NONE, GAP_ELEM, 1'b0}    // at sign
    };

    ascii_to_morse_keying u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // dots and dashes for each character, first element first
    function automatic string itu_pattern(input logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c >= "A" && c <= "Z") begin
            c = c + 8'd32;
        end
        case (c)
            "a": return ".-";      "b": return "-...";    "c": return "-.-.";
            "d": return "-..";     "e": return ".";       "f": return "..-.";
            "g": return "--.";     "h": return "....";    "i": return "..";
            "j": return ".---";    "k": return "-.-";     "l": return ".-..";
            "m": return "--";      "n": return "-.";      "o": return "---";
            "p": return ".--.";    "q": return "--.-";    "r": return ".-.";
            "s": return "...";     "t": return "-";       "u": return "..-";
            "v": return "...-";    "w": return ".--";     "x": return "-..-";
            "y": return "-.--";    "z": return "--..";
            "0": return "-----";   "1": return ".----";   "2": return "..---";
            "3": return "...--";   "4": return "....-";   "5": return ".....";
            "6": return "-....";   "7": return "--...";   "8": return "---..";
            "9": return "----.";
            ".": return ".-.-.-";  ",": return "--..--";  "?": return "..--..";
            "'": return ".----.";  "!": return "-.-.--";  "/": return "-..-.";
            "(": return "-.--.";   ")": return "-.--.-";  "&": return ".-...";
            ":": return "---...";  "=": return "-...-";   "+": return ".-.-.";
            "-": return "-....-";  "\"": return ".-..-."; "@": return ".--.-.";
            default: return "";
        endcase
    endfunction

    // queues the keying of one character and returns how many elements it gives
    function automatic int predict_keying(input logic [7:0] code);
        string        pat;
        keying_elem_t e;
        int           i;
        if (code == CHAR_SPACE) begin
            e = '{MARK_NONE, GAP_WORD, 1'b1};
            pending_elems.push_back(e);
            return 1;
        end
        pat = itu_pattern(code);
        for (i = 0; i < pat.len(); i++) begin
            e.mark = (pat[i] == "-") ? MARK_DASH : MARK_DOT;
            e.last = (i == pat.len() - 1);
            e.gap  = e.last ? GAP_CHAR : GAP_ELEM;
            pending_elems.push_back(e);
        end
        return pat.len();
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("mismatch on %s at output item %0d: expected %0d, got %0d",
                 what, elems_seen, exp_v, got_v);
        fail_count++;
    endtask

    // offers one character, with random idle cycles ahead of it; returns after acceptance
    task automatic send_char(input logic [7:0] code, input bit typed,
                             input keying_elem_t elem, input int n_typed, output int n_out);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do @(posedge aclk); while (!s_tready);
        if (typed) begin
            if (n_typed > 0) pending_elems.push_back(elem);
            n_out = n_typed;
        end else begin
            n_out = predict_keying(code);
        end
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_elems.size() == 0) begin
                report_mismatch("unexpected item", -1, m_tdata);
            end else begin
                want = pending_elems.pop_front();
                if (m_tdata[1:0] !== want.mark) report_mismatch("mark_units", want.mark, m_tdata[1:0]);
                if (m_tdata[4:2] !== want.gap)  report_mismatch("gap_units", want.gap, m_tdata[4:2]);
                if (m_tlast !== want.last)      report_mismatch("last_element", want.last, m_tlast);
                if (m_tdata[7:5] !== 3'b000)    report_mismatch("tdata padding", 0, m_tdata[7:5]);
            end
            elems_seen++;
        end
    end

    // receiver: random stalls, plus one long hold-off while the sender keeps offering
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && elems_seen >= 60) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d output items outstanding", pending_elems.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int           phase;
        int           row;
        int           sent;
        int           n_out;
        int           r;
        logic [7:0]   code;
        keying_elem_t no_elem;

        no_elem  = '0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (row = 0; row < N_ROWS; row++) begin
            send_char(char_rows[row].code, char_rows[row].typed, char_rows[row].elem,
                      char_rows[row].n_elems, n_out);
        end

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    code = itu_chars[$urandom_range(0, itu_chars.len() - 1)];
                end else if (r < 85) begin
                    code = CHAR_SPACE;
                end else begin
                    code = $urandom_range(0, 255);
                end
                send_char(code, 1'b0, no_elem, 0, n_out);
                sent++;
            end
        end

        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_elems.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
